>>> src/mtep_pkg.sv
package mtep_pkg;

	localparam logic [31:0] TRACK_TAG    = 32'h4D54726B;
	localparam logic [7:0]  META_STATUS  = 8'hFF;
	localparam logic [7:0]  META_SEQ     = 8'h7F;
	localparam logic [7:0]  META_TEXT_LO = 8'h01;
	localparam logic [7:0]  META_TEXT_HI = 8'h07;
	localparam logic [7:0]  META_TEMPO   = 8'h51;
	localparam logic [7:0]  META_EOT     = 8'h2F;
	localparam logic [7:0]  SYSEX_END    = 8'hF7;
	localparam logic [7:0]  CC_ALL_OFF   = 8'd123;
	localparam logic [3:0]  SYS_NIBBLE   = 4'hF;
	localparam logic [3:0]  SYSEX_LOW    = 4'h0;
	localparam logic [2:0]  FIELD_LAST   = 3'd3;

	typedef enum logic [3:0] {
		CMD_NONE     = 4'h0,
		CMD_NOTE_OFF = 4'h8,
		CMD_NOTE_ON  = 4'h9,
		CMD_POLY_AT  = 4'hA,
		CMD_CTRL     = 4'hB,
		CMD_PROGRAM  = 4'hC,
		CMD_CHAN_AT  = 4'hD,
		CMD_BEND     = 4'hE
	} cmd_t;

	typedef enum logic [13:0] {
		PH_TAG    = 14'h0001,
		PH_LEN    = 14'h0002,
		PH_DELTA  = 14'h0004,
		PH_STATUS = 14'h0008,
		PH_DATA1  = 14'h0010,
		PH_DATA2  = 14'h0020,
		PH_SKIP   = 14'h0040,
		PH_SYSEX  = 14'h0080,
		PH_MTYPE  = 14'h0100,
		PH_MVLQ   = 14'h0200,
		PH_MLEN   = 14'h0400,
		PH_MBODY  = 14'h0800,
		PH_DONE   = 14'h1000,
		PH_ERROR  = 14'h2000
	} phase_t;

	typedef enum logic [2:0] {
		EV_NOTE_ON  = 3'd0,
		EV_NOTE_OFF = 3'd1,
		EV_ALL_OFF  = 3'd2,
		EV_TEMPO    = 3'd3,
		EV_EOT      = 3'd4,
		EV_ERROR    = 3'd5
	} event_kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  field_cnt;
		logic [31:0] bytes_left;
		logic [31:0] vlq;
		logic [3:0]  run_cmd;
		logic [3:0]  run_ch;
		logic [7:0]  first_data;
		logic [31:0] skip_cnt;
		logic [7:0]  meta_type;
		logic [23:0] tempo;
		logic [31:0] since_note_on;
		logic [31:0] abs_ticks;
	} parse_state_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [3:0]  channel_num;
		logic [6:0]  note_num;
		logic [6:0]  note_velocity;
		logic [31:0] ticks_since_note_on;
		logic [31:0] track_ticks;
		logic [23:0] tempo_us;
	} result_t;

	// handshake between the parser and the output register
	typedef struct packed {
		logic push;
		logic take;
	} out_hs_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

>>> src/mtep_intf.sv
interface mtep_in_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_start;

	modport source (output valid, output data_byte, output track_start, input ready);
	modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if (input logic clk);
	logic                      valid;
	logic                      ready;
	mtep_pkg::event_kind_t     event_kind;
	logic [3:0]                channel_num;
	logic [6:0]                note_num;
	logic [6:0]                note_velocity;
	logic [31:0]               ticks_since_note_on;
	logic [31:0]               track_ticks;
	logic [23:0]               tempo_us;

	modport source (output valid, output event_kind, output channel_num, output note_num,
		output note_velocity, output ticks_since_note_on, output track_ticks,
		output tempo_us, input ready);
	modport sink   (input valid, input event_kind, input channel_num, input note_num,
		input note_velocity, input ticks_since_note_on, input track_ticks,
		input tempo_us, output ready);
endinterface

>>> src/mtep_core.sv
module mtep_core (
	input  logic              clk,
	input  logic              arst_n,
	mtep_in_if.sink           in_ch,
	input  mtep_pkg::out_hs_t hs_in,
	output mtep_pkg::out_hs_t hs_out,
	output mtep_pkg::result_t res
);
	import mtep_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	parse_state_t st_q;
	parse_state_t c;
	parse_state_t n;
	result_t      r;
	logic         emit;
	logic         adv;

	// a byte with no result never waits on the output side
	assign adv          = valid_s1 && (!emit || hs_in.take);
	assign in_ch.ready  = !valid_s1 || adv;
	assign hs_out.push  = valid_s1 && emit && hs_in.take;
	assign hs_out.take  = 1'b0;
	assign res          = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1  <= in_ch.data_byte;
			start_s1 <= in_ch.track_start;
		end
	end

	// phase is the top field of the state word, everything else clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= {PH_TAG, {($bits(parse_state_t) - $bits(phase_t)){1'b0}}};
		end else if (adv) begin
			st_q <= n;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic        fin;
		logic        data_now;
		logic        chan_start;
		logic [31:0] vlq7;
		cmd_t        cmd;

		b          = byte_s1;
		fin        = 1'b0;
		data_now   = 1'b0;
		chan_start = 1'b0;
		emit       = 1'b0;
		cmd        = CMD_NONE;

		if (start_s1) begin
			c       = '0;
			c.phase = PH_TAG;
		end else begin
			c = st_q;
		end
		n    = c;
		vlq7 = {c.vlq[24:0], b[6:0]};

		r                     = '0;
		r.event_kind          = EV_ERROR;
		r.ticks_since_note_on = c.since_note_on;
		r.track_ticks         = c.abs_ticks;

		unique case (c.phase)
			PH_TAG: begin
				n.vlq       = {c.vlq[23:0], b};
				n.field_cnt = c.field_cnt + 3'd1;
				if (c.field_cnt == FIELD_LAST) begin
					n.field_cnt = '0;
					if (n.vlq != TRACK_TAG) begin
						n.phase = PH_ERROR;
						emit    = 1'b1;
					end else begin
						n.bytes_left = '0;
						n.phase      = PH_LEN;
					end
					n.vlq = '0;
				end
			end
			PH_LEN: begin
				n.bytes_left = {c.bytes_left[23:0], b};
				n.field_cnt  = c.field_cnt + 3'd1;
				if (c.field_cnt == FIELD_LAST) begin
					n.field_cnt = '0;
					n.vlq       = '0;
					n.phase     = (n.bytes_left != '0) ? PH_DELTA : PH_DONE;
				end
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
				if (c.bytes_left == '0) begin
					n.phase = PH_DONE;
				end else begin
					n.bytes_left = c.bytes_left - 32'd1;
					unique case (c.phase)
						PH_DELTA: begin
							n.vlq = vlq7;
							if (!b[7]) begin
								n.since_note_on = sat_add(c.since_note_on, vlq7);
								n.abs_ticks     = sat_add(c.abs_ticks, vlq7);
								n.vlq           = '0;
								n.phase         = PH_STATUS;
							end
						end
						PH_STATUS: begin
							if (b == META_STATUS) begin
								n.phase = PH_MTYPE;
							end else if (b[7]) begin
								if (b[7:4] == SYS_NIBBLE) begin
									n.run_cmd = CMD_NONE;
									if (b[3:0] == SYSEX_LOW) begin
										n.phase = PH_SYSEX;
									end else begin
										n.phase = PH_ERROR;
										emit    = 1'b1;
									end
								end else begin
									n.run_cmd  = b[7:4];
									n.run_ch   = b[3:0];
									chan_start = 1'b1;
								end
							end else if (c.run_cmd < CMD_NOTE_OFF || c.run_cmd > CMD_BEND) begin
								n.phase = PH_ERROR;
								emit    = 1'b1;
							end else begin
								data_now   = 1'b1;
								chan_start = 1'b1;
							end
						end
						PH_DATA1: begin
							n.first_data = b;
							n.phase      = PH_DATA2;
						end
						PH_DATA2: begin
							n.phase         = PH_DELTA;
							r.channel_num   = c.run_ch;
							if (c.run_cmd == CMD_CTRL) begin
								if (c.first_data == CC_ALL_OFF) begin
									r.event_kind = EV_ALL_OFF;
									emit         = 1'b1;
								end
							end else begin
								r.note_num      = c.first_data[6:0];
								r.note_velocity = b[6:0];
								emit            = 1'b1;
								if (c.run_cmd == CMD_NOTE_OFF || b[6:0] == 7'd0) begin
									r.event_kind = EV_NOTE_OFF;
								end else begin
									r.event_kind    = EV_NOTE_ON;
									n.since_note_on = '0;
								end
							end
						end
						PH_SKIP: begin
							n.skip_cnt = c.skip_cnt - 32'd1;
							if (n.skip_cnt == '0) n.phase = PH_DELTA;
						end
						PH_SYSEX: begin
							if (b == SYSEX_END) n.phase = PH_DELTA;
						end
						PH_MTYPE: begin
							n.meta_type = b;
							n.tempo     = '0;
							n.vlq       = '0;
							if ((b >= META_TEXT_LO && b <= META_TEXT_HI) || b == META_SEQ)
								n.phase = PH_MVLQ;
							else
								n.phase = PH_MLEN;
						end
						PH_MVLQ: begin
							n.vlq = vlq7;
							if (!b[7]) begin
								n.skip_cnt = vlq7;
								n.vlq      = '0;
								if (vlq7 == '0) fin = 1'b1;
								else            n.phase = PH_MBODY;
							end
						end
						PH_MLEN: begin
							n.skip_cnt = {24'd0, b};
							if (b == 8'd0) fin = 1'b1;
							else           n.phase = PH_MBODY;
						end
						PH_MBODY: begin
							n.tempo    = {c.tempo[15:0], b};
							n.skip_cnt = c.skip_cnt - 32'd1;
							if (n.skip_cnt == '0) fin = 1'b1;
						end
						default: begin
						end
					endcase

					// enter the data bytes of a channel message
					if (chan_start) begin
						cmd = cmd_t'(n.run_cmd);
						case (cmd)
							CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL: begin
								if (data_now) begin
									n.first_data = b;
									n.phase      = PH_DATA2;
								end else begin
									n.phase = PH_DATA1;
								end
							end
							CMD_POLY_AT, CMD_BEND: begin
								n.skip_cnt = data_now ? 32'd1 : 32'd2;
								n.phase    = PH_SKIP;
							end
							default: begin
								if (data_now) begin
									n.phase = PH_DELTA;
								end else begin
									n.skip_cnt = 32'd1;
									n.phase    = PH_SKIP;
								end
							end
						endcase
					end

					if (fin) begin
						if (n.meta_type == META_TEMPO) begin
							n.phase      = PH_DELTA;
							r.event_kind = EV_TEMPO;
							r.tempo_us   = n.tempo;
							emit         = 1'b1;
						end else if (n.meta_type == META_EOT) begin
							n.phase      = PH_DONE;
							r.event_kind = EV_EOT;
							emit         = 1'b1;
						end else begin
							n.phase = PH_DELTA;
						end
					end

					// chunk length used up: drop whatever is left of the event
					if (n.bytes_left == '0 && n.phase != PH_ERROR) n.phase = PH_DONE;
				end
			end
		endcase
	end

endmodule

>>> src/mtep_out_reg.sv
module mtep_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  mtep_pkg::out_hs_t hs_in,
	output mtep_pkg::out_hs_t hs_out,
	input  mtep_pkg::result_t res,
	mtep_out_if.source        out_ch
);
	import mtep_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign hs_out.take = !valid_q || out_ch.ready;
	assign hs_out.push = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hs_in.push) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hs_in.push) res_q <= res;
	end

	assign out_ch.valid               = valid_q;
	assign out_ch.event_kind          = res_q.event_kind;
	assign out_ch.channel_num         = res_q.channel_num;
	assign out_ch.note_num            = res_q.note_num;
	assign out_ch.note_velocity       = res_q.note_velocity;
	assign out_ch.ticks_since_note_on = res_q.ticks_since_note_on;
	assign out_ch.track_ticks         = res_q.track_ticks;
	assign out_ch.tempo_us            = res_q.tempo_us;

endmodule

>>> src/midi_track_event_parser.sv
// MIDI track chunk parser: one byte of an MTrk chunk per transaction on in_ch, track_start set
// on the first byte of each chunk. Each byte passes through a single input register and one
// pass of parse logic, so a byte can be accepted every cycle unless input stalls; a result (note
// on/off, all notes off, set tempo, end of track, format error) is written into the output
// register from the byte held in the input register once the output register can take it.
// Input stalls only when a byte that produces a result meets a full output register that is
// not being drained.
module midi_track_event_parser (
	input  logic       clk,
	input  logic       arst_n,
	mtep_in_if.sink    in_ch,
	mtep_out_if.source out_ch
);
	import mtep_pkg::*;

	out_hs_t core_hs;
	out_hs_t oreg_hs;
	result_t res;

	mtep_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.hs_in  (oreg_hs),
		.hs_out (core_hs),
		.res    (res)
	);

	mtep_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.hs_in  (core_hs),
		.hs_out (oreg_hs),
		.res    (res),
		.out_ch (out_ch)
	);

endmodule

>>> tb/midi_event_checker.sv
`timescale 1ns / 1ps

module midi_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	mtep_in_if          in_mon,
	mtep_out_if         out_mon,
	output int unsigned fail_count,
	output int unsigned pending
);
	import mtep_pkg::*;

	// parser shadow state
	phase_t      ph;
	logic [2:0]  hdr_cnt;
	logic [31:0] remaining;
	logic [31:0] vlq;
	cmd_t        run_cmd;
	logic [3:0]  run_ch;
	logic [7:0]  data1;
	logic [31:0] skip_left;
	logic [7:0]  meta_kind;
	logic [23:0] tempo_acc;
	logic [31:0] since_on;
	logic [31:0] track_abs;

	result_t     expected_events[$];
	result_t     want;
	result_t     ev;
	int unsigned mismatches = 0;
	int unsigned queued = 0;

	assign fail_count = mismatches;
	assign pending    = queued;

	function automatic void clear_parser();
		ph        = PH_TAG;
		hdr_cnt   = '0;
		remaining = '0;
		vlq       = '0;
		run_cmd   = CMD_NONE;
		run_ch    = '0;
		data1     = '0;
		skip_left = '0;
		meta_kind = '0;
		tempo_acc = '0;
		since_on  = '0;
		track_abs = '0;
	endfunction

	function automatic logic [31:0] add_ticks(input logic [31:0] a, input logic [31:0] b);
		return (b > ~a) ? 32'hFFFF_FFFF : a + b;
	endfunction

	function automatic result_t stamp_event(input event_kind_t kind, input logic [3:0] ch,
		input logic [7:0] note, input logic [7:0] vel, input logic [23:0] tempo);
		result_t r;
		r.event_kind          = kind;
		r.channel_num         = ch;
		r.note_num            = note[6:0];
		r.note_velocity       = vel[6:0];
		r.ticks_since_note_on = since_on;
		r.track_ticks         = track_abs;
		r.tempo_us            = tempo;
		return r;
	endfunction

	function automatic logic close_meta(output result_t r);
		r = '0;
		if (meta_kind == META_TEMPO) begin
			ph = PH_DELTA;
			r  = stamp_event(EV_TEMPO, '0, '0, '0, tempo_acc);
			return 1'b1;
		end
		if (meta_kind == META_EOT) begin
			ph = PH_DONE;
			r  = stamp_event(EV_EOT, '0, '0, '0, '0);
			return 1'b1;
		end
		ph = PH_DELTA;
		return 1'b0;
	endfunction

	// data_now: the current byte is already the first data byte (running status)
	function automatic void enter_channel(input logic [7:0] b, input logic data_now);
		case (run_cmd)
			CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CTRL: begin
				if (data_now) begin
					data1 = b;
					ph    = PH_DATA2;
				end else
					ph = PH_DATA1;
			end
			CMD_POLY_AT, CMD_BEND: begin
				skip_left = data_now ? 32'd1 : 32'd2;
				ph        = PH_SKIP;
			end
			default: begin
				if (data_now)
					ph = PH_DELTA;
				else begin
					skip_left = 32'd1;
					ph        = PH_SKIP;
				end
			end
		endcase
	endfunction

	function automatic logic parse_track_byte(input logic [7:0] b, input logic start,
		output result_t r);
		logic hit;
		hit = 1'b0;
		r   = '0;
		if (start)
			clear_parser();
		case (ph)
			PH_TAG: begin
				vlq = {vlq[23:0], b};
				hdr_cnt++;
				if (hdr_cnt == 3'd4) begin
					hdr_cnt = '0;
					if (vlq != TRACK_TAG) begin
						r   = stamp_event(EV_ERROR, '0, '0, '0, '0);
						ph  = PH_ERROR;
						hit = 1'b1;
					end else begin
						remaining = '0;
						ph        = PH_LEN;
					end
					vlq = '0;
				end
			end
			PH_LEN: begin
				remaining = {remaining[23:0], b};
				hdr_cnt++;
				if (hdr_cnt == 3'd4) begin
					hdr_cnt = '0;
					vlq     = '0;
					ph      = (remaining != 0) ? PH_DELTA : PH_DONE;
				end
			end
			PH_DONE, PH_ERROR: ;
			default: begin
				if (remaining == 0)
					ph = PH_DONE;
				else begin
					remaining--;
					case (ph)
						PH_DELTA: begin
							vlq = {vlq[24:0], b[6:0]};
							if (!b[7]) begin
								since_on  = add_ticks(since_on, vlq);
								track_abs = add_ticks(track_abs, vlq);
								vlq       = '0;
								ph        = PH_STATUS;
							end
						end
						PH_STATUS: begin
							if (b == META_STATUS)
								ph = PH_MTYPE;
							else if (b[7:4] == SYS_NIBBLE) begin
								run_cmd = CMD_NONE;
								if (b[3:0] == SYSEX_LOW)
									ph = PH_SYSEX;
								else begin
									r   = stamp_event(EV_ERROR, '0, '0, '0, '0);
									ph  = PH_ERROR;
									hit = 1'b1;
								end
							end else if (b[7]) begin
								run_cmd = cmd_t'(b[7:4]);
								run_ch  = b[3:0];
								enter_channel(b, 1'b0);
							end else if (run_cmd == CMD_NONE) begin
								r   = stamp_event(EV_ERROR, '0, '0, '0, '0);
								ph  = PH_ERROR;
								hit = 1'b1;
							end else
								enter_channel(b, 1'b1);
						end
						PH_DATA1: begin
							data1 = b;
							ph    = PH_DATA2;
						end
						PH_DATA2: begin
							ph = PH_DELTA;
							if (run_cmd == CMD_CTRL) begin
								if (data1 == CC_ALL_OFF) begin
									r   = stamp_event(EV_ALL_OFF, run_ch, '0, '0, '0);
									hit = 1'b1;
								end
							end else if (run_cmd == CMD_NOTE_OFF || b[6:0] == 7'd0) begin
								r   = stamp_event(EV_NOTE_OFF, run_ch, data1, b, '0);
								hit = 1'b1;
							end else begin
								r        = stamp_event(EV_NOTE_ON, run_ch, data1, b, '0);
								since_on = '0;
								hit      = 1'b1;
							end
						end
						PH_SKIP: begin
							skip_left--;
							if (skip_left == 0)
								ph = PH_DELTA;
						end
						PH_SYSEX: begin
							if (b == SYSEX_END)
								ph = PH_DELTA;
						end
						PH_MTYPE: begin
							meta_kind = b;
							tempo_acc = '0;
							vlq       = '0;
							ph = ((b >= META_TEXT_LO && b <= META_TEXT_HI) || b == META_SEQ) ?
								PH_MVLQ : PH_MLEN;
						end
						PH_MVLQ: begin
							vlq = {vlq[24:0], b[6:0]};
							if (!b[7]) begin
								skip_left = vlq;
								vlq       = '0;
								if (skip_left == 0)
									hit = close_meta(r);
								else
									ph = PH_MBODY;
							end
						end
						PH_MLEN: begin
							skip_left = {24'd0, b};
							if (skip_left == 0)
								hit = close_meta(r);
							else
								ph = PH_MBODY;
						end
						PH_MBODY: begin
							tempo_acc = {tempo_acc[15:0], b};
							skip_left--;
							if (skip_left == 0)
								hit = close_meta(r);
						end
						default: ;
					endcase
					// chunk length exhausted, even mid-event
					if (remaining == 0 && ph != PH_ERROR)
						ph = PH_DONE;
				end
			end
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		mismatches++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_events.delete();
			queued = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_events.size() == 0)
					report_mismatch("event kind, nothing pending", 32'(out_mon.event_kind), '0);
				else begin
					want = expected_events.pop_front();
					check_field("event_kind", 32'(out_mon.event_kind), 32'(want.event_kind));
					check_field("channel_num", 32'(out_mon.channel_num), 32'(want.channel_num));
					check_field("note_num", 32'(out_mon.note_num), 32'(want.note_num));
					check_field("note_velocity", 32'(out_mon.note_velocity),
						32'(want.note_velocity));
					check_field("ticks_since_note_on", out_mon.ticks_since_note_on,
						want.ticks_since_note_on);
					check_field("track_ticks", out_mon.track_ticks, want.track_ticks);
					check_field("tempo_us", 32'(out_mon.tempo_us), 32'(want.tempo_us));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				if (parse_track_byte(in_mon.data_byte, in_mon.track_start, ev))
					expected_events.push_back(ev);
			end
			queued = expected_events.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mtep_pkg::*;

	localparam int unsigned ITEM_TARGET    = 1700;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam logic [7:0]  VLQ_MORE       = 8'h80;

	logic clk = 1'b0;
	logic arst_n;

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned stall_asks = 0;
	int unsigned stall_seen = 0;
	int unsigned items_sent = 0;
	int unsigned fail_count;
	int unsigned pending;
	logic [7:0]  body_q[$];
	logic [7:0]  last_status;

	mtep_in_if  in_ch (clk);
	mtep_out_if out_ch (clk);

	midi_track_event_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	midi_event_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] data7();
		// now and then a data byte with the top bit set
		return ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
	endfunction

	task automatic add_vlq(input logic [31:0] v, input int unsigned pad);
		logic [7:0] grp[$];
		grp.push_front({1'b0, v[6:0]});
		v = v >> 7;
		while (v != 0) begin
			grp.push_front({1'b1, v[6:0]});
			v = v >> 7;
		end
		repeat (pad) grp.push_front(VLQ_MORE);
		foreach (grp[i])
			body_q.push_back(grp[i]);
	endtask

	task automatic add_delta();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 40)
			body_q.push_back(8'h00);
		else if (pick < 75)
			add_vlq($urandom_range(1, 127), 0);
		else if (pick < 90)
			add_vlq($urandom_range(16383), (pick == 89) ? 1 : 0);
		else if (pick < 98)
			add_vlq($urandom_range(32'h0FFF_FFFF), 0);
		else begin
			// five groups or more: the accumulator wraps
			n = $urandom_range(5, 7);
			repeat (n - 1) body_q.push_back(VLQ_MORE | 8'($urandom_range(127)));
			body_q.push_back(8'($urandom_range(127)));
		end
	endtask

	task automatic add_end_of_track();
		body_q.push_back(8'h00);
		body_q.push_back(META_STATUS);
		body_q.push_back(META_EOT);
		body_q.push_back(8'h00);
	endtask

	task automatic add_event();
		int unsigned pick;
		int unsigned n;
		logic [3:0]  ch;
		logic [7:0]  st;
		logic [7:0]  mtype;
		cmd_t        kind;
		pick = $urandom_range(99);
		ch   = 4'($urandom_range(15));
		add_delta();
		if (pick < 42 || pick >= 96) begin
			kind = (pick < 30 || pick >= 96) ? CMD_NOTE_ON : CMD_NOTE_OFF;
			st   = {kind, ch};
			if (last_status[7:4] == kind && $urandom_range(1) == 1) begin
				st = last_status;
			end else begin
				body_q.push_back(st);
			end
			last_status = st;
			body_q.push_back(data7());
			if (kind == CMD_NOTE_ON && $urandom_range(6) == 0)
				body_q.push_back($urandom_range(1) ? 8'h00 : VLQ_MORE);
			else
				body_q.push_back(data7());
		end else if (pick < 50) begin
			st = {CMD_CTRL, ch};
			body_q.push_back(st);
			last_status = st;
			body_q.push_back($urandom_range(1) ? CC_ALL_OFF : data7());
			body_q.push_back(data7());
		end else if (pick < 56) begin
			st = {($urandom_range(1) ? CMD_POLY_AT : CMD_BEND), ch};
			body_q.push_back(st);
			last_status = st;
			body_q.push_back(data7());
			body_q.push_back(data7());
		end else if (pick < 61) begin
			st = {($urandom_range(1) ? CMD_PROGRAM : CMD_CHAN_AT), ch};
			body_q.push_back(st);
			last_status = st;
			body_q.push_back(data7());
		end else if (pick < 66) begin
			body_q.push_back({SYS_NIBBLE, SYSEX_LOW});
			last_status = '0;
			n = $urandom_range(6);
			repeat (n) body_q.push_back(8'($urandom_range(127)));
			if ($urandom_range(9) != 0)
				body_q.push_back(SYSEX_END);
		end else if (pick < 74) begin
			body_q.push_back(META_STATUS);
			body_q.push_back(META_TEMPO);
			n = ($urandom_range(99) < 80) ? 3 : $urandom_range(6);
			body_q.push_back(8'(n));
			repeat (n) body_q.push_back(8'($urandom_range(255)));
		end else if (pick < 80) begin
			body_q.push_back(META_STATUS);
			body_q.push_back($urandom_range(1) ? 8'($urandom_range(META_TEXT_LO, META_TEXT_HI))
				: META_SEQ);
			n = ($urandom_range(19) == 0) ? $urandom_range(128, 160) : $urandom_range(12);
			add_vlq(n, ($urandom_range(9) == 0) ? 1 : 0);
			repeat (n) body_q.push_back(8'($urandom_range(255)));
		end else if (pick < 85) begin
			mtype = 8'($urandom_range(255));
			body_q.push_back(META_STATUS);
			body_q.push_back(mtype);
			n = $urandom_range(6);
			body_q.push_back(8'(n));
			repeat (n) body_q.push_back(8'($urandom_range(255)));
		end else if (pick < 87) begin
			body_q.push_back({SYS_NIBBLE, 4'($urandom_range(1, 14))});
			last_status = '0;
		end else if (pick < 89) begin
			// sysex drops running status, so the bare data byte has no status
			body_q.push_back({SYS_NIBBLE, SYSEX_LOW});
			body_q.push_back(SYSEX_END);
			body_q.push_back(8'h00);
			body_q.push_back(8'($urandom_range(127)));
			last_status = '0;
		end else if (pick < 93)
			body_q.push_back(8'($urandom_range(255)));
		else
			add_end_of_track();
	endtask

	task automatic send_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.data_byte   <= b;
		in_ch.track_start <= st;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_chunk(input logic [31:0] tag, input logic [31:0] len);
		logic [63:0] hdr;
		hdr = {tag, len};
		for (int i = 7; i >= 0; i--)
			send_byte(hdr[i*8 +: 8], i == 7);
		foreach (body_q[i])
			send_byte(body_q[i], 1'b0);
		items_sent += 8 + body_q.size();
		body_q.delete();
	endtask

	task automatic random_track();
		int unsigned n_ev;
		int unsigned mode;
		logic [31:0] tag;
		logic [31:0] len;
		n_ev = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		last_status = '0;
		repeat (n_ev) add_event();
		if ($urandom_range(99) < 70) begin
			add_end_of_track();
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 4)) body_q.push_back(8'($urandom_range(255)));
		end
		mode = $urandom_range(99);
		if (mode < 80)
			len = body_q.size();
		else if (mode < 90)
			len = $urandom_range(body_q.size());
		else if (mode < 97)
			len = body_q.size() + $urandom_range(1, 6);
		else
			len = 32'hFFFF_FFFF;
		tag = TRACK_TAG;
		if ($urandom_range(99) < 4)
			tag = tag ^ (32'd1 << $urandom_range(31));
		send_chunk(tag, len);
		// stray bytes between chunks
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
	endtask

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_asks != stall_seen) begin
				stall_seen = stall_asks;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.data_byte   = '0;
		in_ch.track_start = 1'b0;
		last_status       = '0;
		send_idle_pct     = 37;
		recv_idle_pct     = 82;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// broken tag
		send_chunk(TRACK_TAG ^ 32'h0000_0100, 32'd0);
		// zero length: body is ignored
		body_q = '{8'h00, {CMD_NOTE_ON, 4'h0}, 8'h3C, 8'h40};
		send_chunk(TRACK_TAG, 32'd0);
		// notes, running status with velocity 0, all notes off, tempo, saturating deltas, EOT
		body_q = '{8'h00, {CMD_NOTE_ON, 4'hF}, 8'h7F, 8'h7F,
			8'h81, 8'h00, 8'h00, 8'h00,
			8'h00, {CMD_CTRL, 4'h5}, CC_ALL_OFF, 8'h00,
			8'h00, META_STATUS, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
			8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {CMD_NOTE_OFF, 4'h0}, 8'h00, 8'h00,
			8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, {CMD_NOTE_ON, 4'h1}, 8'hFF, 8'h01,
			8'h00, META_STATUS, META_EOT, 8'h00, 8'h55};
		send_chunk(TRACK_TAG, 32'd39);
		// data byte with no status held
		body_q = '{8'h00, 8'h3C, 8'h40};
		send_chunk(TRACK_TAG, 32'd3);
		// reserved system status
		body_q = '{8'h00, {SYS_NIBBLE, 4'hD}, 8'h00};
		send_chunk(TRACK_TAG, 32'd3);

		while (items_sent < ITEM_TARGET / 3) random_track();
		send_idle_pct <= 82;
		recv_idle_pct <= 37;
		while (items_sent < 2 * ITEM_TARGET / 3) random_track();
		send_idle_pct <= 0;
		recv_idle_pct <= 0;

		// note-on burst against a held-off receiver: input has to stall
		stall_asks <= stall_asks + 1;
		repeat (40) begin
			body_q.push_back(8'h00);
			body_q.push_back({CMD_NOTE_ON, 4'h3});
			body_q.push_back(8'($urandom_range(127)));
			body_q.push_back(8'($urandom_range(1, 127)));
		end
		send_chunk(TRACK_TAG, 32'd160);

		while (items_sent < ITEM_TARGET) random_track();
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
src/mtep_pkg.sv
src/mtep_intf.sv
src/mtep_core.sv
src/mtep_out_reg.sv
src/midi_track_event_parser.sv
tb/midi_event_checker.sv
tb/tb_top.sv
